// ===== src/scaled_text_glyph_rect_generator_core_macros.svh =====
// Assertion macros for the glyph rectangle generator.
`ifndef SCALED_TEXT_GLYPH_RECT_GENERATOR_CORE_MACROS_SVH
`define SCALED_TEXT_GLYPH_RECT_GENERATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define STGR_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

`define STGR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`else

`define STGR_ASSERT_IMPLY(label, clk, rst, pre, post, msg)

`define STGR_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

// ===== src/stgr_pkg.sv =====
// Types, constants and the 5x7 font table for the glyph rectangle generator.
package stgr_pkg;

   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;
   localparam int FONT_DEPTH  = 95;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] FIRST_CODE   = 8'h20;
   localparam logic [7:0] LAST_CODE    = 8'h7E;
   localparam logic [7:0] SUBST_CODE   = 8'h3F;

   localparam logic [2:0] SPACER_COL = 3'(GLYPH_COLS);
   localparam logic [2:0] LAST_ROW   = 3'(GLYPH_ROWS - 1);

   localparam logic [1:0] CSR_FG_COLOR    = 2'd0;
   localparam logic [1:0] CSR_BG_COLOR    = 2'd1;
   localparam logic [1:0] CSR_GLYPH_SCALE = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic [7:0] start_x;
      logic [7:0] start_y;
      logic       first;
   } req_type;

   typedef struct packed {
      logic [7:0]  rect_x;
      logic [7:0]  rect_y;
      logic [3:0]  rect_w;
      logic [5:0]  rect_h;
      logic [15:0] rect_color;
      logic        visible;
      logic        last_rect;
   } rsp_type;

   // one drawn character handed from front to back
   typedef struct packed {
      logic [7:0]                             x;
      logic [7:0]                             y;
      logic [3:0]                             scale;
      logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] bits;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   // column 0 in the top byte, bit 0 of each byte is the top row
   localparam logic [39:0] FONT_ROM [FONT_DEPTH] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
   };

endpackage

// ===== src/scaled_text_glyph_rect_generator_core.sv =====
// Top level of the scaled 5x7 text glyph rectangle generator.
//
//  channel | direction | handshake            | carries
//  req_    | in        | req_valid/req_ready  | char_code, start_x, start_y, first
//  rsp_    | out       | rsp_valid/rsp_ready  | one clipped rectangle per item
//  csr_    | in        | csr_valid/csr_ready  | register index and write data
//
// A drawn character gives 36 rectangles from the back-end cell walker, one per cycle
// unless rsp_ready stalls it; rsp_valid is registered after the job enters the queue.
// A newline only updates the cursor in the front end and gives no rectangles.
// Two queued jobs let the front end keep taking characters while the back end draws.
// Reset clears the cursor, line start, queue and output valid, and loads register defaults.
// A stalled rsp_ready holds the output register; the walker waits until it is taken.
`include "scaled_text_glyph_rect_generator_core_macros.svh"

module scaled_text_glyph_rect_generator_core #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 128,
   parameter int MAX_SCALE    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stgr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stgr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import stgr_pkg::*;

   localparam logic [8:0] PANEL_W9 = 9'(PANEL_WIDTH);
   localparam logic [8:0] PANEL_H9 = 9'(PANEL_HEIGHT);

   logic [15:0] fg_color_ff, fg_color_in;
   logic [15:0] bg_color_ff, bg_color_in;
   logic [3:0]  glyph_scale_ff, glyph_scale_in;

   logic         csr_write;
   logic         q_push, q_pop;
   job_type      q_job, head_job;
   q_status_type q_status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      fg_color_in    = fg_color_ff;
      bg_color_in    = bg_color_ff;
      glyph_scale_in = glyph_scale_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FG_COLOR:    fg_color_in    = csr_data;
            CSR_BG_COLOR:    bg_color_in    = csr_data;
            CSR_GLYPH_SCALE: glyph_scale_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff    <= 16'hFFFF;
         bg_color_ff    <= 16'h0000;
         glyph_scale_ff <= 4'd1;
      end else begin
         fg_color_ff    <= fg_color_in;
         bg_color_ff    <= bg_color_in;
         glyph_scale_ff <= glyph_scale_in;
      end
   end

   stgr_front #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .MAX_SCALE   (MAX_SCALE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .glyph_scale (glyph_scale_ff),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (q_job)
   );

   stgr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   stgr_back #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .fg_color  (fg_color_ff),
      .bg_color  (bg_color_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `STGR_ASSERT_NEXT(a_pop_emits_spacer, clock, reset, q_pop,
      rsp_valid && rsp_data.last_rect, "job popped without a spacer rectangle")
   `STGR_ASSERT_IMPLY(a_spacer_bg, clock, reset, rsp_valid && rsp_data.last_rect,
      rsp_data.rect_color == bg_color_ff, "spacer not in background color")
   `STGR_ASSERT_IMPLY(a_clip_x, clock, reset, rsp_valid && rsp_data.visible,
      ({1'b0, rsp_data.rect_x} + 9'(rsp_data.rect_w)) <= PANEL_W9,
      "visible rectangle runs past panel width")
   `STGR_ASSERT_IMPLY(a_origin_on_panel, clock, reset, rsp_valid && rsp_data.visible,
      {1'b0, rsp_data.rect_y} < PANEL_H9, "visible rectangle origin below panel")

endmodule

// ===== src/stgr_front.sv =====
// Front end: takes characters, tracks the cursor, looks up the glyph, queues a job.
module stgr_front #(
   parameter int PANEL_WIDTH = 128,
   parameter int MAX_SCALE   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stgr_pkg::req_type     req_data,
   input  logic [3:0]            glyph_scale,
   input  stgr_pkg::q_status_type q_status,
   output logic                  q_push,
   output stgr_pkg::job_type     q_job
);
   import stgr_pkg::*;

   localparam logic [8:0] PANEL_W9  = 9'(PANEL_WIDTH);
   localparam logic [4:0] MAX_SCL5  = 5'(MAX_SCALE);

   logic [7:0] cursor_x_ff, cursor_x_in;
   logic [7:0] cursor_y_ff, cursor_y_in;
   logic [7:0] line_start_x_ff, line_start_x_in;

   logic        accept;
   logic        is_newline;
   logic        wrap;
   logic [3:0]  scale;
   logic [6:0]  six_s;
   logic [6:0]  eight_s;
   logic [7:0]  base_x, base_y, line_x;
   logic [7:0]  draw_x, draw_y;
   logic [7:0]  glyph_code;
   logic [6:0]  glyph_idx;
   logic [39:0] glyph_word;

   assign req_ready  = !q_status.full;
   assign accept     = req_valid && req_ready;
   assign is_newline = (req_data.char_code == NEWLINE_CODE);

   always_comb begin
      if (glyph_scale == 4'd0) begin
         scale = 4'd1;
      end else if ({1'b0, glyph_scale} > MAX_SCL5) begin
         scale = MAX_SCL5[3:0];
      end else begin
         scale = glyph_scale;
      end
   end

   assign six_s   = 7'({3'b000, scale} * 7'd6);
   assign eight_s = {scale, 3'b000};

   assign base_x = req_data.first ? req_data.start_x : cursor_x_ff;
   assign base_y = req_data.first ? req_data.start_y : cursor_y_ff;
   assign line_x = req_data.first ? req_data.start_x : line_start_x_ff;

   assign wrap   = is_newline || (({1'b0, base_x} + {2'b00, six_s}) > PANEL_W9);
   assign draw_x = wrap ? line_x : base_x;
   assign draw_y = wrap ? 8'(base_y + {1'b0, eight_s}) : base_y;

   assign cursor_x_in     = accept ? (is_newline ? draw_x : 8'(draw_x + {1'b0, six_s}))
                                   : cursor_x_ff;
   assign cursor_y_in     = accept ? draw_y : cursor_y_ff;
   assign line_start_x_in = accept ? line_x : line_start_x_ff;

   // unprintable codes draw as '?'
   assign glyph_code = (req_data.char_code < FIRST_CODE || req_data.char_code > LAST_CODE)
                       ? SUBST_CODE : req_data.char_code;
   assign glyph_idx  = 7'(glyph_code - FIRST_CODE);
   assign glyph_word = FONT_ROM[glyph_idx];

   always_comb begin
      q_job.x     = draw_x;
      q_job.y     = draw_y;
      q_job.scale = scale;
      for (int k = 0; k < GLYPH_COLS; k++) begin
         q_job.bits[k] = glyph_word[32 - 8*k +: GLYPH_ROWS];
      end
   end

   assign q_push = accept && !is_newline;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         line_start_x_ff <= '0;
      end else begin
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         line_start_x_ff <= line_start_x_in;
      end
   end

endmodule

// ===== src/stgr_queue.sv =====
// Short job queue between the front end and the rectangle sequencer.
module stgr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  stgr_pkg::job_type      push_job,
   input  logic                   pop,
   output stgr_pkg::job_type      head_job,
   output stgr_pkg::q_status_type status
);
   import stgr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   job_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == DEPTH_CNT);
   assign head_job         = entries_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/stgr_back.sv =====
// Back end: walks the 35 cells and the spacer of the head job, clips, registers output.
module stgr_back #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stgr_pkg::job_type      head_job,
   input  stgr_pkg::q_status_type q_status,
   output logic                   q_pop,
   input  logic [15:0]            fg_color,
   input  logic [15:0]            bg_color,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stgr_pkg::rsp_type      rsp_data
);
   import stgr_pkg::*;

   localparam logic [8:0] PANEL_W9 = 9'(PANEL_WIDTH);
   localparam logic [8:0] PANEL_H9 = 9'(PANEL_HEIGHT);

   logic [2:0] col_ff, col_in;
   logic [2:0] row_ff, row_in;
   logic [7:0] xoff_ff, xoff_in;
   logic [7:0] yoff_ff, yoff_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       advance;
   logic       spacer;
   logic       dot;
   logic [2:0] col_idx;
   logic [7:0] cell_x, cell_y;
   logic [8:0] w_raw, h_raw, w_clip, h_clip;
   logic       vis;

   assign advance = q_status.not_empty && (!rsp_valid_ff || rsp_ready);
   assign spacer  = (col_ff == SPACER_COL);
   assign q_pop   = advance && spacer;

   assign col_idx = spacer ? '0 : col_ff;
   assign dot     = !spacer && head_job.bits[col_idx][row_ff];
   assign cell_x  = 8'(head_job.x + xoff_ff);
   assign cell_y  = 8'(head_job.y + yoff_ff);
   assign w_raw   = {5'b0, head_job.scale};
   assign h_raw   = spacer ? 9'({5'b0, head_job.scale} * 9'(GLYPH_ROWS)) : w_raw;

   // clip only when the origin lands on the panel
   assign vis    = ({1'b0, cell_x} < PANEL_W9) && ({1'b0, cell_y} < PANEL_H9);
   assign w_clip = (vis && ({1'b0, cell_x} + w_raw > PANEL_W9))
                   ? 9'(PANEL_W9 - {1'b0, cell_x}) : w_raw;
   assign h_clip = (vis && ({1'b0, cell_y} + h_raw > PANEL_H9))
                   ? 9'(PANEL_H9 - {1'b0, cell_y}) : h_raw;

   always_comb begin
      rsp_data_in.rect_x     = cell_x;
      rsp_data_in.rect_y     = cell_y;
      rsp_data_in.rect_w     = w_clip[3:0];
      rsp_data_in.rect_h     = h_clip[5:0];
      rsp_data_in.rect_color = dot ? fg_color : bg_color;
      rsp_data_in.visible    = vis;
      rsp_data_in.last_rect  = spacer;
   end

   // column-major walk: rows 0..6 of columns 0..4, then the spacer column
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      xoff_in = xoff_ff;
      yoff_in = yoff_ff;
      if (advance) begin
         if (spacer) begin
            col_in  = '0;
            row_in  = '0;
            xoff_in = '0;
            yoff_in = '0;
         end else if (row_ff == LAST_ROW) begin
            col_in  = 3'(col_ff + 1'b1);
            row_in  = '0;
            xoff_in = 8'(xoff_ff + {4'b0, head_job.scale});
            yoff_in = '0;
         end else begin
            row_in  = 3'(row_ff + 1'b1);
            yoff_in = 8'(yoff_ff + {4'b0, head_job.scale});
         end
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         xoff_ff      <= '0;
         yoff_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         xoff_ff      <= xoff_in;
         yoff_ff      <= yoff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
